// ===== hdl/bce_pkg.sv =====
`default_nettype none

package bce_pkg;

   typedef struct packed {
      logic [9:0] current_sample;
      logic [9:0] voltage_sample;
   } req_type;

   typedef struct packed {
      logic [9:0]         current_value;
      logic [11:0]        voltage_value;
      logic signed [31:0] charge_estimate;
      logic [17:0]        charge_percent;
      logic [18:0]        check_sum;
   } rsp_type;

   localparam int CSR_W     = 10;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_CURRENT_OFFSET  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLTAGE_GAIN    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLTAGE_DIVISOR = 2'd2;

   localparam logic signed [9:0] CUR_OFFSET_RST = 10'sd0;
   localparam logic [7:0]        GAIN_RST       = 8'd64;
   localparam logic [7:0]        DIVISOR_RST    = 8'd66;

   // voltage divider: 12 quotient bits, four per stage
   localparam int QUO_W     = 12;
   localparam int DIV_STEPS = 4;

   localparam logic [11:0] VOLT_MAX = 12'hFFF;

   // load offset: x / 25 as (x * 1311) >> 15, exact for x below 4096
   localparam logic [10:0] OFF_RECIP = 11'd1311;
   localparam int          OFF_SHIFT = 15;
   localparam logic [7:0]  OFF_MID   = 8'd32;

   localparam logic signed [13:0] KNEE_HIGH = 14'sd765;
   localparam logic signed [13:0] KNEE_MID  = 14'sd706;

   localparam logic signed [17:0] SLOPE_HIGH = -18'sd36864;
   localparam logic signed [17:0] SLOPE_MID  = -18'sd102010;
   localparam logic signed [17:0] SLOPE_LOW  = -18'sd31933;

   localparam logic signed [31:0] BASE_HIGH = 32'sd30505000;
   localparam logic signed [31:0] BASE_MID  = 32'sd80293000;
   localparam logic signed [31:0] BASE_LOW  = 32'sd30835000;

   localparam logic signed [31:0] FULL_CHARGE = 32'sd9216000;

   // percent: used * 100 / 92160 = ((used * 5) >> 9) / 9, the last as reciprocal
   localparam logic [20:0] PCT_RECIP = 21'd1864136;
   localparam int          PCT_SHIFT = 24;

endpackage

`default_nettype wire

// ===== hdl/battery_charge_estimator.sv =====
// Battery charge estimator: each request carries one raw current and one raw voltage sample and
// yields one response with the corrected current, the scaled voltage, a three-segment charge
// figure, the used-capacity percentage and their checksum. The block is a ten-stage pipeline that
// takes one request per clock unless a stalled output has filled every stage; a stalled output
// holds its response while earlier stages keep filling any empty slots. The voltage gain/divisor
// quotient comes from three restoring divider stages of four bits each, and the two constant
// divisions are done by reciprocal multipliers. A divisor of zero, or a scaled voltage above 4095,
// gives 4095. The user must write configuration registers only while idle; nothing enforces it.
`default_nettype none

module battery_charge_estimator (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire bce_pkg::req_type              req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output bce_pkg::rsp_type                   rsp_data,
   input  wire logic                          csr_we,
   input  wire logic [bce_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [bce_pkg::CSR_W-1:0]     csr_wdata
);
   import bce_pkg::*;

   localparam int NSTG = 10;

   typedef enum logic [1:0] {SEG_LOW, SEG_MID, SEG_HIGH} seg_type;

   // configuration
   logic signed [9:0] cur_off_ff;
   logic [7:0]        gain_ff;
   logic [7:0]        div_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_off_ff <= CUR_OFFSET_RST;
         gain_ff    <= GAIN_RST;
         div_ff     <= DIVISOR_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CURRENT_OFFSET:  cur_off_ff <= csr_wdata[9:0];
            CSR_VOLTAGE_GAIN:    gain_ff    <= csr_wdata[7:0];
            CSR_VOLTAGE_DIVISOR: div_ff     <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic [NSTG-1:0] v_ff, v_in, en;

   always_comb begin
      en[NSTG-1] = !v_ff[NSTG-1] || rsp_ready;
      for (int k = NSTG-2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      v_in[0] = en[0] ? req_valid : v_ff[0];
      for (int k = 1; k < NSTG; k++) begin
         v_in[k] = en[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = v_ff[NSTG-1];

   // stage 1: current correction, voltage product
   logic signed [11:0] cdiff;
   logic [9:0]         s1_cval_in, s1_cval_ff;
   logic [17:0]        s1_prod_in, s1_prod_ff;

   always_comb begin
      cdiff = $signed({2'b00, req_data.current_sample}) - $signed({{2{cur_off_ff[9]}}, cur_off_ff});
      if (cdiff < 12'sd0) begin
         s1_cval_in = 10'd0;
      end else if (cdiff > 12'sd1023) begin
         s1_cval_in = 10'd1023;
      end else begin
         s1_cval_in = cdiff[9:0];
      end
      s1_prod_in = 18'(req_data.voltage_sample) * 18'(gain_ff);
   end

   // stage 2: overflow check, load offset magnitude
   logic [7:0]  half, mag;
   logic        s2_neg_in, s2_neg_ff;
   logic [11:0] s2_y_in, s2_y_ff;
   logic        s2_ovf_in, s2_ovf_ff;
   logic [9:0]  s2_cval_ff;

   always_comb begin
      s2_ovf_in = (div_ff == 8'd0) || ({2'b00, s1_prod_ff[17:12]} >= div_ff);
      half      = s1_cval_ff[9] ? s1_cval_ff[8:1] : 8'd0;
      if (half <= OFF_MID) begin
         mag       = OFF_MID - half;
         s2_neg_in = 1'b0;
      end else begin
         mag       = half - OFF_MID;
         s2_neg_in = 1'b1;
      end
      s2_y_in = {1'b0, mag, 3'b000} + {2'b00, mag, 2'b00};
   end

   // stage 3: load offset
   logic [21:0]       offp;
   logic [7:0]        offq;
   logic signed [7:0] s3_off_in, s3_off_ff;
   logic              s3_ovf_ff;
   logic [9:0]        s3_cval_ff;

   always_comb begin
      offp      = 22'(s2_y_ff) * 22'(OFF_RECIP);
      offq      = {1'b0, offp[OFF_SHIFT +: 7]};
      s3_off_in = s2_neg_ff ? $signed(8'd0 - offq) : $signed(offq);
   end

   // stage 4: last quotient bits
   logic signed [7:0] s4_off_ff;
   logic              s4_ovf_ff;
   logic [9:0]        s4_cval_ff;

   // voltage divider stages 2 to 4
   logic [7:0]       rem_a, rem_b, rem_c;
   logic [QUO_W-1:0] quo_a, quo_b, quo_c;

   bce_div_stage u_div_a (
      .clock   (clock),
      .en      (en[1]),
      .div     (div_ff),
      .src_rem ({2'b00, s1_prod_ff[17:12]}),
      .src_quo (s1_prod_ff[11:0]),
      .dst_rem (rem_a),
      .dst_quo (quo_a)
   );

   bce_div_stage u_div_b (
      .clock   (clock),
      .en      (en[2]),
      .div     (div_ff),
      .src_rem (rem_a),
      .src_quo (quo_a),
      .dst_rem (rem_b),
      .dst_quo (quo_b)
   );

   bce_div_stage u_div_c (
      .clock   (clock),
      .en      (en[3]),
      .div     (div_ff),
      .src_rem (rem_b),
      .src_quo (quo_b),
      .dst_rem (rem_c),
      .dst_quo (quo_c)
   );

   // stage 5: voltage, segment select
   logic [11:0]        s5_vval_in, s5_vval_ff;
   logic signed [13:0] s5_d_in, s5_d_ff;
   seg_type            s5_seg_in, s5_seg_ff;
   logic [9:0]         s5_cval_ff;

   always_comb begin
      s5_vval_in = s4_ovf_ff ? VOLT_MAX : quo_c;
      s5_d_in    = $signed({2'b00, s5_vval_in}) - $signed({{6{s4_off_ff[7]}}, s4_off_ff});
      if (s5_d_in >= KNEE_HIGH) begin
         s5_seg_in = SEG_HIGH;
      end else if (s5_d_in >= KNEE_MID) begin
         s5_seg_in = SEG_MID;
      end else begin
         s5_seg_in = SEG_LOW;
      end
   end

   // stage 6: slope product
   logic signed [17:0] slope;
   logic signed [31:0] s6_prod_in, s6_prod_ff;
   seg_type            s6_seg_ff;
   logic [9:0]         s6_cval_ff;
   logic [11:0]        s6_vval_ff;

   always_comb begin
      case (s5_seg_ff)
         SEG_HIGH: slope = SLOPE_HIGH;
         SEG_MID:  slope = SLOPE_MID;
         default:  slope = SLOPE_LOW;
      endcase
      s6_prod_in = 32'(slope) * 32'(s5_d_ff);
   end

   // stage 7: charge figure, used capacity
   logic signed [31:0] base;
   logic signed [31:0] s7_charge_in, s7_charge_ff;
   logic signed [31:0] s7_used_in, s7_used_ff;
   logic [9:0]         s7_cval_ff;
   logic [11:0]        s7_vval_ff;

   always_comb begin
      case (s6_seg_ff)
         SEG_HIGH: base = BASE_HIGH;
         SEG_MID:  base = BASE_MID;
         default:  base = BASE_LOW;
      endcase
      s7_charge_in = s6_prod_ff + base;
      s7_used_in   = FULL_CHARGE - s7_charge_in;
   end

   // stage 8: used * 5 / 512
   logic [29:0]        used5;
   logic [20:0]        s8_s_in, s8_s_ff;
   logic signed [31:0] s8_charge_ff;
   logic [9:0]         s8_cval_ff;
   logic [11:0]        s8_vval_ff;

   always_comb begin
      used5   = {s7_used_ff[27:0], 2'b00} + 30'(s7_used_ff[27:0]);
      s8_s_in = (!s7_used_ff[31] && (s7_used_ff != 32'sd0)) ? used5[29:9] : 21'd0;
   end

   // stage 9: divide by nine
   logic [41:0]        pmul;
   logic [17:0]        s9_pct_in, s9_pct_ff;
   logic signed [31:0] s9_charge_ff;
   logic [9:0]         s9_cval_ff;
   logic [11:0]        s9_vval_ff;

   always_comb begin
      pmul      = 42'(s8_s_ff) * 42'(PCT_RECIP);
      s9_pct_in = pmul[PCT_SHIFT +: 18];
   end

   // stage 10: response register
   rsp_type rsp_in, rsp_ff;

   always_comb begin
      rsp_in.current_value   = s9_cval_ff;
      rsp_in.voltage_value   = s9_vval_ff;
      rsp_in.charge_estimate = s9_charge_ff;
      rsp_in.charge_percent  = s9_pct_ff;
      rsp_in.check_sum       = 19'(s9_cval_ff) + 19'(s9_vval_ff) + 19'(s9_pct_ff);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_cval_ff <= s1_cval_in;
         s1_prod_ff <= s1_prod_in;
      end
      if (en[1]) begin
         s2_cval_ff <= s1_cval_ff;
         s2_ovf_ff  <= s2_ovf_in;
         s2_neg_ff  <= s2_neg_in;
         s2_y_ff    <= s2_y_in;
      end
      if (en[2]) begin
         s3_cval_ff <= s2_cval_ff;
         s3_ovf_ff  <= s2_ovf_ff;
         s3_off_ff  <= s3_off_in;
      end
      if (en[3]) begin
         s4_cval_ff <= s3_cval_ff;
         s4_ovf_ff  <= s3_ovf_ff;
         s4_off_ff  <= s3_off_ff;
      end
      if (en[4]) begin
         s5_cval_ff <= s4_cval_ff;
         s5_vval_ff <= s5_vval_in;
         s5_d_ff    <= s5_d_in;
         s5_seg_ff  <= s5_seg_in;
      end
      if (en[5]) begin
         s6_cval_ff <= s5_cval_ff;
         s6_vval_ff <= s5_vval_ff;
         s6_prod_ff <= s6_prod_in;
         s6_seg_ff  <= s5_seg_ff;
      end
      if (en[6]) begin
         s7_cval_ff   <= s6_cval_ff;
         s7_vval_ff   <= s6_vval_ff;
         s7_charge_ff <= s7_charge_in;
         s7_used_ff   <= s7_used_in;
      end
      if (en[7]) begin
         s8_cval_ff   <= s7_cval_ff;
         s8_vval_ff   <= s7_vval_ff;
         s8_charge_ff <= s7_charge_ff;
         s8_s_ff      <= s8_s_in;
      end
      if (en[8]) begin
         s9_cval_ff   <= s8_cval_ff;
         s9_vval_ff   <= s8_vval_ff;
         s9_charge_ff <= s8_charge_ff;
         s9_pct_ff    <= s9_pct_in;
      end
      if (en[9]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

// ===== hdl/bce_div_stage.sv =====
`default_nettype none

module bce_div_stage (
   input  wire logic                      clock,
   input  wire logic                      en,
   input  wire logic [7:0]                div,
   input  wire logic [7:0]                src_rem,
   input  wire logic [bce_pkg::QUO_W-1:0] src_quo,
   output logic      [7:0]                dst_rem,
   output logic      [bce_pkg::QUO_W-1:0] dst_quo
);
   import bce_pkg::*;

   logic [7:0]       rem_ff, rem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [8:0]       trial;

   // shift-in restoring division, dividend bits leave the top of quo as quotient bits enter
   always_comb begin
      rem_in = src_rem;
      quo_in = src_quo;
      trial  = 9'd0;
      for (int i = 0; i < DIV_STEPS; i++) begin
         trial  = {rem_in, quo_in[QUO_W-1]};
         quo_in = {quo_in[QUO_W-2:0], 1'b0};
         if (trial >= {1'b0, div}) begin
            trial     = trial - {1'b0, div};
            quo_in[0] = 1'b1;
         end
         rem_in = trial[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign dst_rem = rem_ff;
   assign dst_quo = quo_ff;

endmodule

`default_nettype wire

// ===== tb/bce_checker.sv =====
`timescale 1ns / 1ps

module bce_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_ready,
   input  wire bce_pkg::req_type              req_data,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire bce_pkg::rsp_type              rsp_data,
   input  wire logic                          csr_we,
   input  wire logic [bce_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [bce_pkg::CSR_W-1:0]     csr_wdata,
   output int                                 error_count,
   output int                                 pending_count,
   output int                                 checked_count
);

   import bce_pkg::*;

   logic signed [9:0] offset_q;
   logic [7:0]        gain_q;
   logic [7:0]        divisor_q;
   rsp_type           pending_readings[$];
   rsp_type           want;
   int                bad;

   function automatic rsp_type estimate_charge(input req_type r, input logic signed [9:0] off,
                                               input logic [7:0] gain, input logic [7:0] div);
      longint  cur;
      longint  volt;
      longint  load;
      longint  shift;
      longint  delta;
      longint  charge;
      longint  used;
      longint  pct;
      rsp_type p;
      cur = longint'(r.current_sample) - longint'(off);
      if (cur < 0) cur = 0;
      if (cur > 1023) cur = 1023;
      if (div == 8'd0) begin
         volt = 4095;
      end else begin
         volt = (longint'(r.voltage_sample) * longint'(gain)) / longint'(div);
         if (volt > 4095) volt = 4095;
      end
      // load current rounded down to even, negative load counts as none
      load = cur - 512;
      if (load < 0) begin
         load = -((-load + 1) / 2) * 2;
      end else begin
         load = (load / 2) * 2;
      end
      if (load < 0) load = 0;
      shift = ((64 - load) * 24) / 100;
      delta = volt - shift;
      if (volt >= 765 + shift) begin
         charge = -36864 * delta + 30505000;
      end else if (volt >= 706 + shift) begin
         charge = -102010 * delta + 80293000;
      end else begin
         charge = -31933 * delta + 30835000;
      end
      used = 9216000 - charge;
      if (used > 0) begin
         pct = (used * 100) / 92160;
         if (pct > 262143) pct = 262143;
      end else begin
         pct = 0;
      end
      p.current_value   = 10'(cur);
      p.voltage_value   = 12'(volt);
      p.charge_estimate = 32'(charge);
      p.charge_percent  = 18'(pct);
      p.check_sum       = 19'(cur + volt + pct);
      return p;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         pending_readings.delete();
         offset_q      <= CUR_OFFSET_RST;
         gain_q        <= GAIN_RST;
         divisor_q     <= DIVISOR_RST;
         error_count   <= 0;
         pending_count <= 0;
         checked_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_readings.size() == 0) begin
               $error("response with no request outstanding");
               error_count <= error_count + 1;
            end else begin
               want = pending_readings.pop_front();
               bad  = 0;
               if (rsp_data.current_value !== want.current_value) begin
                  $error("current_value: expected %0d, got %0d",
                         want.current_value, rsp_data.current_value);
                  bad++;
               end
               if (rsp_data.voltage_value !== want.voltage_value) begin
                  $error("voltage_value: expected %0d, got %0d",
                         want.voltage_value, rsp_data.voltage_value);
                  bad++;
               end
               if (rsp_data.charge_estimate !== want.charge_estimate) begin
                  $error("charge_estimate: expected %0d, got %0d",
                         want.charge_estimate, rsp_data.charge_estimate);
                  bad++;
               end
               if (rsp_data.charge_percent !== want.charge_percent) begin
                  $error("charge_percent: expected %0d, got %0d",
                         want.charge_percent, rsp_data.charge_percent);
                  bad++;
               end
               if (rsp_data.check_sum !== want.check_sum) begin
                  $error("check_sum: expected %0d, got %0d",
                         want.check_sum, rsp_data.check_sum);
                  bad++;
               end
               error_count   <= error_count + bad;
               checked_count <= checked_count + 1;
            end
         end
         if (req_valid && req_ready) begin
            pending_readings.push_back(estimate_charge(req_data, offset_q, gain_q, divisor_q));
         end
         if (csr_we) begin
            case (csr_index)
               CSR_CURRENT_OFFSET: begin
                  offset_q <= csr_wdata[9:0];
               end
               CSR_VOLTAGE_GAIN: begin
                  gain_q <= csr_wdata[7:0];
               end
               CSR_VOLTAGE_DIVISOR: begin
                  divisor_q <= csr_wdata[7:0];
               end
               default: begin
               end
            endcase
         end
         pending_count <= pending_readings.size();
      end
   end

endmodule

// ===== tb/battery_charge_estimator_tb.sv =====
`timescale 1ns / 1ps

module battery_charge_estimator_tb;

   import bce_pkg::*;

   localparam int ITEM_TARGET = 1450;
   localparam int PHASES      = 6;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 400000;

   typedef enum int {DRAIN_FREE, DRAIN_HALF, DRAIN_SLOW, DRAIN_MOSTLY} drain_mode_type;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   req_type              req_data  = '0;
   logic                 rsp_ready = 1'b0;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;
   logic                 req_ready;
   logic                 rsp_valid;
   rsp_type              rsp_data;

   int             error_count;
   int             pending_count;
   int             checked_count;
   int             sent          = 0;
   int             settings_used = 0;
   int             cycle_count   = 0;
   int             burst_left    = 0;
   logic [7:0]     cfg_gain      = GAIN_RST;
   logic [7:0]     cfg_div       = DIVISOR_RST;
   logic           hold_start    = 1'b0;
   logic           hold_done     = 1'b0;
   int             hold_left     = 0;
   drain_mode_type mode          = DRAIN_FREE;
   int             mode_left     = 0;

   battery_charge_estimator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   bce_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   // response side: random stall patterns, plus one long hold-off on demand
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_start && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            mode      <= drain_mode_type'($urandom_range(0, 3));
            mode_left <= $urandom_range(4, 64);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (mode)
            DRAIN_FREE: begin
               rsp_ready <= 1'b1;
            end
            DRAIN_HALF: begin
               rsp_ready <= 1'($urandom_range(0, 1));
            end
            DRAIN_SLOW: begin
               rsp_ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
               rsp_ready <= ($urandom_range(0, 7) != 0);
            end
         endcase
      end
   end

   task automatic send_sample(input logic [9:0] cur, input logic [9:0] volt);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= req_type'{current_sample: cur, voltage_sample: volt};
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic configure(input logic signed [9:0] off, input logic [7:0] gain,
                            input logic [7:0] div);
      csr_we    <= 1'b1;
      csr_index <= CSR_CURRENT_OFFSET;
      csr_wdata <= off;
      @(posedge clock);
      csr_index <= CSR_VOLTAGE_GAIN;
      csr_wdata <= CSR_W'(gain);
      @(posedge clock);
      csr_index <= CSR_VOLTAGE_DIVISOR;
      csr_wdata <= CSR_W'(div);
      @(posedge clock);
      csr_we   <= 1'b0;
      cfg_gain = gain;
      cfg_div  = div;
      settings_used++;
   endtask

   // about half the time, aim the scaled voltage at the knees of the charge fit
   task automatic send_random();
      logic [9:0] cur;
      logic [9:0] volt;
      int         aim;
      if ($urandom_range(0, 9) < 4) begin
         cur = 10'($urandom_range(0, 1023));
      end else begin
         cur = 10'($urandom_range(440, 640));
      end
      if ($urandom_range(0, 1) == 0 || cfg_div == 8'd0) begin
         volt = 10'($urandom_range(0, 1023));
      end else begin
         aim = ($urandom_range(600, 900) * cfg_div + cfg_gain - 1) / cfg_gain;
         volt = (aim > 1023) ? 10'd1023 : 10'(aim);
      end
      send_sample(cur, volt);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset register values: fit segments and load current edges
      send_sample(10'd0, 10'd0);
      send_sample(10'd1023, 10'd1023);
      send_sample(10'd512, 10'd805);
      send_sample(10'd512, 10'd804);
      send_sample(10'd512, 10'd744);
      send_sample(10'd512, 10'd743);
      send_sample(10'd513, 10'd600);
      send_sample(10'd511, 10'd600);
      send_sample(10'd1023, 10'd900);
      send_sample(10'd1023, 10'd700);
      send_sample(10'd0, 10'd1023);
      send_sample(10'd700, 10'd780);
      settle();

      // current saturates high, voltage overflows
      configure(-10'sd512, 8'd255, 8'd1);
      send_sample(10'd0, 10'd0);
      send_sample(10'd600, 10'd17);
      send_sample(10'd1023, 10'd1023);
      settle();

      // current saturates low
      configure(10'sd511, 8'd1, 8'd255);
      send_sample(10'd0, 10'd1023);
      send_sample(10'd1023, 10'd0);
      send_sample(10'd200, 10'd512);
      settle();

      // zero divisor
      configure(10'sd0, 8'd255, 8'd0);
      send_sample(10'd512, 10'd0);
      send_sample(10'd300, 10'd1023);
      settle();

      for (int p = 0; p < PHASES; p++) begin
         if (p == 0) begin
            configure(CUR_OFFSET_RST, GAIN_RST, DIVISOR_RST);
         end else if (p == PHASES - 1) begin
            configure(10'($urandom_range(0, 1023)), 8'($urandom_range(1, 255)), 8'd0);
         end else if (p % 2 == 0) begin
            configure(10'($urandom_range(0, 1023)), 8'($urandom_range(1, 255)),
                      8'($urandom_range(1, 255)));
         end else begin
            configure(10'($urandom_range(0, 1023)), 8'($urandom_range(100, 255)),
                      8'($urandom_range(90, 140)));
         end
         for (int i = 0; i < ITEM_TARGET / PHASES; i++) begin
            if (p == 1 && i == 60) hold_start <= 1'b1;
            send_random();
         end
         settle();
      end

      repeat (20) @(posedge clock);
      $display("%0d requests over %0d register settings, %0d responses checked",
               sent, settings_used, checked_count);
      $display("covered saturation, zero divisor, all fit segments and a %0d-cycle output hold",
               HOLD_CYCLES);
      if (error_count == 0 && pending_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== battery_charge_estimator.f =====
hdl/bce_pkg.sv
hdl/bce_div_stage.sv
hdl/battery_charge_estimator.sv
tb/bce_checker.sv
tb/battery_charge_estimator_tb.sv
